// ===== hdl/integer_to_roman_numeral_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer-to-Roman-numeral unit
// Concurrent checks on a clocked design with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define IRN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define IRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define IRN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IRN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/irn_pkg.sv =====
// ----------------------------------------------------------------------------
// irn_pkg
// Types, constants and the control store of the Roman numeral sequencer.
// ----------------------------------------------------------------------------
package irn_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 7;
    localparam int PC_W    = 5;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // ASCII letters
    localparam logic [SYM_W-1:0] CH_I = 7'h49;
    localparam logic [SYM_W-1:0] CH_V = 7'h56;
    localparam logic [SYM_W-1:0] CH_X = 7'h58;
    localparam logic [SYM_W-1:0] CH_L = 7'h4C;
    localparam logic [SYM_W-1:0] CH_C = 7'h43;
    localparam logic [SYM_W-1:0] CH_D = 7'h44;
    localparam logic [SYM_W-1:0] CH_M = 7'h4D;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // One microinstruction: test remainder >= weight; on a hit emit the letter,
    // subtract and go to next_hit, otherwise go to next_miss. Weight zero is
    // an unconditional emit. pair_head marks the first letter of CM, XC, IX...
    typedef struct packed {
        logic [VALUE_W-1:0] weight;
        logic [SYM_W-1:0]   letter;
        logic               pair_head;
        logic [PC_W-1:0]    next_hit;
        logic [PC_W-1:0]    next_miss;
    } t_uword;

    typedef struct packed {
        logic               load;
        logic               sub;
        logic [VALUE_W-1:0] weight;
    } t_dp_ctl;

    typedef struct packed {
        logic hit;
        logic zero_after;
    } t_dp_sts;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = '{12'd1000, CH_M, 1'b0, 5'd0,  5'd1};
            5'd1:    w = '{12'd900,  CH_C, 1'b1, 5'd2,  5'd3};
            5'd2:    w = '{12'd0,    CH_M, 1'b0, 5'd7,  5'd7};
            5'd3:    w = '{12'd500,  CH_D, 1'b0, 5'd6,  5'd4};
            5'd4:    w = '{12'd400,  CH_C, 1'b1, 5'd5,  5'd6};
            5'd5:    w = '{12'd0,    CH_D, 1'b0, 5'd7,  5'd7};
            5'd6:    w = '{12'd100,  CH_C, 1'b0, 5'd6,  5'd7};
            5'd7:    w = '{12'd90,   CH_X, 1'b1, 5'd8,  5'd9};
            5'd8:    w = '{12'd0,    CH_C, 1'b0, 5'd13, 5'd13};
            5'd9:    w = '{12'd50,   CH_L, 1'b0, 5'd12, 5'd10};
            5'd10:   w = '{12'd40,   CH_X, 1'b1, 5'd11, 5'd12};
            5'd11:   w = '{12'd0,    CH_L, 1'b0, 5'd13, 5'd13};
            5'd12:   w = '{12'd10,   CH_X, 1'b0, 5'd12, 5'd13};
            5'd13:   w = '{12'd9,    CH_I, 1'b1, 5'd14, 5'd15};
            5'd14:   w = '{12'd0,    CH_X, 1'b0, 5'd18, 5'd18};
            5'd15:   w = '{12'd5,    CH_V, 1'b0, 5'd18, 5'd16};
            5'd16:   w = '{12'd4,    CH_I, 1'b1, 5'd17, 5'd18};
            5'd17:   w = '{12'd0,    CH_V, 1'b0, 5'd18, 5'd18};
            5'd18:   w = '{12'd1,    CH_I, 1'b0, 5'd18, 5'd18};
            default: w = '{12'd0,    CH_I, 1'b0, 5'd0,  5'd0};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/irn_dp.sv =====
// ----------------------------------------------------------------------------
// irn_dp
// Remainder register with saturating load, compare and subtract.
// ----------------------------------------------------------------------------
module irn_dp (
    input  logic                        i_clk,
    input  irn_pkg::t_dp_ctl            i_ctl,
    input  logic [irn_pkg::VALUE_W-1:0] i_value,
    output irn_pkg::t_dp_sts            o_sts
);
    import irn_pkg::*;

    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] n_rem;
    logic [VALUE_W-1:0] diff;

    assign diff = r_rem - i_ctl.weight;

    always_comb begin
        n_rem = r_rem;
        if (i_ctl.load) begin
            n_rem = (i_value > MAX_VALUE) ? MAX_VALUE : i_value;
        end else if (i_ctl.sub) begin
            n_rem = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_sts.hit        = (r_rem >= i_ctl.weight);
    assign o_sts.zero_after = (diff == '0);

endmodule

// ===== hdl/integer_to_roman_numeral_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_unit
// After acceptance the unit walks the control store; the first letter comes
// at the first step that hits. One letter per cycle on a hit; a control-store
// step that misses emits no letter, and the next start can be taken in the
// cycle after the last letter. Zero gives no letter.
// Synchronous active-low reset returns to idle; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "integer_to_roman_numeral_unit_macros.svh"

module integer_to_roman_numeral_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [irn_pkg::VALUE_W-1:0] i_value,
    output logic                        busy,
    output logic                        o_strobe,
    output logic [irn_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last
);
    import irn_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    t_dp_ctl         dp_ctl;
    t_dp_sts         dp_sts;
    logic            accept;
    logic            done;

    assign uw     = ucode(r_pc);
    assign accept = start && (r_state == ST_IDLE);
    assign done   = dp_sts.hit && dp_sts.zero_after && !uw.pair_head;

    irn_dp u_dp (
        .i_clk   (i_clk),
        .i_ctl   (dp_ctl),
        .i_value (i_value),
        .o_sts   (dp_sts)
    );

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_value != '0)) begin
                    n_state = ST_RUN;
                end
                n_pc = '0;
            end
            ST_RUN: begin
                n_pc = dp_sts.hit ? uw.next_hit : uw.next_miss;
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy          = (r_state == ST_RUN);
        o_strobe      = (r_state == ST_RUN) && dp_sts.hit;
        o_symbol      = uw.letter;
        o_last        = (r_state == ST_RUN) && done;
        dp_ctl.load   = accept;
        dp_ctl.sub    = (r_state == ST_RUN) && dp_sts.hit;
        dp_ctl.weight = uw.weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    `IRN_ASSERT_IMPLY(a_last_needs_strobe, i_clk, i_rst_n, o_last, o_strobe && busy)
    `IRN_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_strobe && o_last, !busy)
    `IRN_ASSERT_NEXT(a_zero_stays_idle, i_clk, i_rst_n, accept && (i_value == '0), !busy)
    `IRN_ASSERT_NEXT(a_miss_moves_on, i_clk, i_rst_n, busy && !o_strobe, r_pc != $past(r_pc))
    `IRN_ASSERT_IMPLY(a_pc_in_store, i_clk, i_rst_n, busy, r_pc <= 5'd18)

endmodule
